### rtl/hvn_pkg.sv
package hvn_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] DIM_RESET = 11'd256;
  localparam logic [CFG_W-1:0] DIM_MIN   = 11'd2;

  localparam logic [0:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [0:0] REG_MAP_HEIGHT = 1'b1;

  localparam int HT_W    = 8;
  localparam int SUM_W   = 11;
  localparam int MAG_W   = 10;
  localparam int SY_W    = 7;
  localparam int SQ_W    = 20;
  localparam int LEN_W   = 21;
  localparam int FRAC_SH = 28;
  localparam int DIVD_W  = SQ_W + FRAC_SH;
  localparam int QUO_W   = 29;
  localparam int ROOT_W  = 15;
  localparam int RREM_W  = 19;
  localparam int OUTS_W  = 16;
  localparam int OUTY_W  = 15;
  localparam int VTX_W   = 10;
  localparam int CNT_W   = 6;
  localparam int WIN_N   = 7;

  localparam logic [SY_W-1:0] FACE_UP = 7'd15;

  localparam logic [CNT_W-1:0] RD_LAST   = 6'd7;
  localparam logic [CNT_W-1:0] SQ_LAST   = 6'd2;
  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd48;
  localparam logic [CNT_W-1:0] ROOT_LAST = 6'd16;
  localparam logic [1:0]       COMP_LAST = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_READ = 8'b0000_0010,
    ST_SUM  = 8'b0000_0100,
    ST_SQ   = 8'b0000_1000,
    ST_LEN  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_ROOT = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic [2:0] rd_idx;
    logic       cap_en;
    logic [2:0] cap_idx;
    logic       sum;
    logic       pass;
    logic       sq_en;
    logic       len;
    logic       div_init;
    logic       div_step;
    logic       root_init;
    logic       root_step;
    logic       q_store;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic first_row;
    logic final_row;
  } stat_t;

endpackage

### rtl/hvn_ctrl.sv
module hvn_ctrl
  import hvn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output logic  in_ready,
  output logic  out_valid,
  output cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic             pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    comp_nxt  = comp_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.pass  = pass_r;
    cmd.comp  = comp_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.take = 1'b1;
          pass_nxt = 1'b0;
          if (!stat.first_row) state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en   = (cnt_r != RD_LAST);
        cmd.rd_idx  = cnt_r[2:0];
        cmd.cap_en  = (cnt_r != '0);
        cmd.cap_idx = cnt_r[2:0] - 3'd1;
        if (cnt_r == RD_LAST) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_en = 1'b1;
        cmd.comp  = cnt_r[1:0];
        if (cnt_r == SQ_LAST) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.len   = 1'b1;
        cnt_nxt   = '0;
        comp_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_init = (cnt_r == '0);
        cmd.div_step = (cnt_r != '0);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd.root_init = (cnt_r == '0);
        cmd.root_step = (cnt_r != '0) && (cnt_r != ROOT_LAST);
        cmd.q_store   = (cnt_r == ROOT_LAST);
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt = '0;
          if (comp_r == COMP_LAST) begin
            state_nxt = ST_OUT;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_OUT: begin
        cnt_nxt = '0;
        if (out_ready) begin
          if (!pass_r && stat.final_row) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/hvn_dp.sv
module hvn_dp
  import hvn_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic [HT_W-1:0]          in_height_sample,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  output logic signed [OUTS_W-1:0] out_normal_x,
  output logic [OUTY_W-1:0]        out_normal_y,
  output logic signed [OUTS_W-1:0] out_normal_z,
  output logic [VTX_W-1:0]         out_vertex_column,
  output logic [VTX_W-1:0]         out_vertex_row,
  output logic                     out_last_of_run
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [CFG_W-1:0] w_eff, h_eff;

  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [1:0]    slot_cnt_r;
  logic          col_wrap, row_wrap;

  logic [CW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic [1:0]      slot_r;
  logic [HT_W-1:0] hin_r;

  logic [HT_W-1:0] ring [DEPTH];
  logic [HT_W-1:0] rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic [HT_W-1:0] win_r [WIN_N];
  logic [1:0]      s1, s2;
  logic [CW-1:0]   cm1, cp1;

  logic                    en_l, en_r, en_t;
  logic signed [SUM_W-1:0] sx_sum, sz_sum;
  logic [SY_W-1:0]         sy_sum;
  logic signed [SUM_W-1:0] sx_r, sz_r;
  logic [SY_W-1:0]         sy_r;

  logic [MAG_W-1:0] mag_x, mag_z, mag_sel;
  logic [SQ_W-1:0]  sq_prod;
  logic [SQ_W-1:0]  sq_r [3];
  logic [LEN_W-1:0] len_sum, len_r;

  logic [LEN_W-1:0]  drem_r;
  logic [DIVD_W-1:0] dq_r;
  logic [LEN_W:0]    dshift;
  logic              dge;

  logic [2*ROOT_W-1:0] rn_r;
  logic [ROOT_W-1:0]   root_r;
  logic [RREM_W-1:0]   rrem_r, rrem2, rtrial;
  logic [ROOT_W-1:0]   q_r [3];

  function automatic logic [AW-1:0] ring_addr(input logic [1:0] s, input logic [CW-1:0] c);
    return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
  endfunction

  function automatic logic signed [SUM_W-1:0] hdiff(input logic [HT_W-1:0] a,
                                                    input logic [HT_W-1:0] b);
    return $signed({{(SUM_W-HT_W){1'b0}}, a}) - $signed({{(SUM_W-HT_W){1'b0}}, b});
  endfunction

  // effective dimensions, clamped to [2, MAX]
  always_comb begin
    if (cfg_w_r < DIM_MIN)                 w_eff = DIM_MIN;
    else if (32'(cfg_w_r) > 32'(MAX_WIDTH)) w_eff = CFG_W'(MAX_WIDTH);
    else                                   w_eff = cfg_w_r;
    if (cfg_h_r < DIM_MIN)                  h_eff = DIM_MIN;
    else if (32'(cfg_h_r) > 32'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
    else                                    h_eff = cfg_h_r;
  end

  assign col_wrap = (32'(col_cnt_r) + 32'd1) >= 32'(w_eff);
  assign row_wrap = (32'(row_cnt_r) + 32'd1) >= 32'(h_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r    <= DIM_RESET;
      cfg_h_r    <= DIM_RESET;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      slot_cnt_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAP_WIDTH) cfg_w_r <= cfg_data;
      if (cfg_index == REG_MAP_HEIGHT) cfg_h_r <= cfg_data;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      slot_cnt_r <= '0;
    end else if (cmd.take) begin
      if (col_wrap) begin
        col_cnt_r <= '0;
        if (row_wrap) begin
          row_cnt_r  <= '0;
          slot_cnt_r <= '0;
        end else begin
          row_cnt_r  <= row_cnt_r + 1'b1;
          slot_cnt_r <= (slot_cnt_r == 2'd2) ? 2'd0 : slot_cnt_r + 2'd1;
        end
      end else begin
        col_cnt_r <= col_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      col_r  <= col_cnt_r;
      row_r  <= row_cnt_r;
      slot_r <= slot_cnt_r;
      hin_r  <= in_height_sample;
    end
  end

  assign stat.first_row = (row_cnt_r == '0);
  assign stat.final_row = (32'(row_r) + 32'd1) == 32'(h_eff);

  // row slots of r-1 and r-2
  assign s1  = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;
  assign s2  = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
  assign cm1 = col_r - 1'b1;
  assign cp1 = col_r + 1'b1;

  always_comb begin
    case (cmd.rd_idx)
      3'd0:    rd_addr = ring_addr(s2, cm1);
      3'd1:    rd_addr = ring_addr(s2, col_r);
      3'd2:    rd_addr = ring_addr(s2, cp1);
      3'd3:    rd_addr = ring_addr(s1, cm1);
      3'd4:    rd_addr = ring_addr(s1, col_r);
      3'd5:    rd_addr = ring_addr(s1, cp1);
      3'd6:    rd_addr = ring_addr(slot_r, cm1);
      default: rd_addr = ring_addr(slot_r, col_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) ring[ring_addr(slot_cnt_r, col_cnt_r)] <= in_height_sample;
    if (cmd.rd_en) rd_data_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_en) win_r[cmd.cap_idx] <= rd_data_r;
  end

  // face sums; window: 0..2 row r-2, 3..5 row r-1, 6 row r at c-1
  assign en_l = (col_r != '0);
  assign en_r = (32'(col_r) + 32'd2) <= 32'(w_eff);
  assign en_t = !cmd.pass && (32'(row_r) >= 32'd2);

  always_comb begin
    sx_sum = '0;
    sz_sum = '0;
    sy_sum = '0;
    if (en_t && en_l) begin
      sx_sum = sx_sum + hdiff(win_r[0], win_r[1]);
      sz_sum = sz_sum + hdiff(win_r[0], win_r[3]);
      sy_sum = sy_sum + FACE_UP;
    end
    if (en_t && en_r) begin
      sx_sum = sx_sum + hdiff(win_r[1], win_r[2]);
      sz_sum = sz_sum + hdiff(win_r[1], win_r[4]);
      sy_sum = sy_sum + FACE_UP;
    end
    if (en_l) begin
      sx_sum = sx_sum + hdiff(win_r[3], win_r[4]);
      sz_sum = sz_sum + hdiff(win_r[3], win_r[6]);
      sy_sum = sy_sum + FACE_UP;
    end
    if (en_r) begin
      sx_sum = sx_sum + hdiff(win_r[4], win_r[5]);
      sz_sum = sz_sum + hdiff(win_r[4], hin_r);
      sy_sum = sy_sum + FACE_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sx_r <= sx_sum;
      sy_r <= sy_sum;
      sz_r <= sz_sum;
    end
  end

  assign mag_x = sx_r[SUM_W-1] ? MAG_W'(-sx_r) : MAG_W'(sx_r);
  assign mag_z = sz_r[SUM_W-1] ? MAG_W'(-sz_r) : MAG_W'(sz_r);

  always_comb begin
    case (cmd.comp)
      2'd0:    mag_sel = mag_x;
      2'd1:    mag_sel = MAG_W'(sy_r);
      default: mag_sel = mag_z;
    endcase
  end

  assign sq_prod = SQ_W'(mag_sel) * SQ_W'(mag_sel);
  assign len_sum = LEN_W'(sq_r[0]) + LEN_W'(sq_r[1]) + LEN_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.sq_en) sq_r[cmd.comp] <= sq_prod;
    if (cmd.len) len_r <= (len_sum == '0) ? LEN_W'(1) : len_sum;
  end

  // restoring divide: (s^2 << 28) / len, one bit a beat
  assign dshift = {drem_r, dq_r[DIVD_W-1]};
  assign dge    = dshift >= {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_r <= '0;
      dq_r   <= {sq_r[cmd.comp], {FRAC_SH{1'b0}}};
    end else if (cmd.div_step) begin
      drem_r <= dge ? LEN_W'(dshift - {1'b0, len_r}) : LEN_W'(dshift);
      dq_r   <= {dq_r[DIVD_W-2:0], dge};
    end
  end

  // integer square root of the quotient, two bits a step
  assign rrem2  = {rrem_r[RREM_W-3:0], rn_r[2*ROOT_W-1 -: 2]};
  assign rtrial = RREM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rn_r   <= (2*ROOT_W)'(dq_r[QUO_W-1:0]);
      root_r <= '0;
      rrem_r <= '0;
    end else if (cmd.root_step) begin
      rn_r <= {rn_r[2*ROOT_W-3:0], 2'b00};
      if (rrem2 >= rtrial) begin
        rrem_r <= rrem2 - rtrial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rrem_r <= rrem2;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.q_store) q_r[cmd.comp] <= root_r;
  end

  assign out_normal_x = sx_r[SUM_W-1] ? $signed(OUTS_W'(0) - OUTS_W'(q_r[0]))
                                      : $signed(OUTS_W'(q_r[0]));
  assign out_normal_y = OUTY_W'(q_r[1]);
  assign out_normal_z = sz_r[SUM_W-1] ? $signed(OUTS_W'(0) - OUTS_W'(q_r[2]))
                                      : $signed(OUTS_W'(q_r[2]));
  assign out_vertex_column = VTX_W'(col_r);
  assign out_vertex_row    = cmd.pass ? VTX_W'(row_r) : VTX_W'(row_r - 1'b1);
  assign out_last_of_run   = cmd.pass || !stat.final_row;

endmodule

### rtl/heightmap_vertex_normal_stream.sv
// Flow: a first-row beat is only written to the row ring and gives no normal; any other beat
// runs 7 ring reads, the face sums, the three squares and their sum, then per component a
// restoring divide and a square root before its normal is shown; a final-row beat gives a
// second normal, for the final row itself, after the first is taken.
// One beat at a time: the next sample is taken only once the last normal has been taken.
// Reset (rst_n low, synchronous): map_width/map_height to 256, counters and control to
// zero; the row ring is not cleared.
module heightmap_vertex_normal_stream
  import hvn_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [HT_W-1:0]          in_height_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUTS_W-1:0] out_normal_x,
  output logic [OUTY_W-1:0]        out_normal_y,
  output logic signed [OUTS_W-1:0] out_normal_z,
  output logic [VTX_W-1:0]         out_vertex_column,
  output logic [VTX_W-1:0]         out_vertex_row,
  output logic                     out_last_of_run
);

  cmd_t  cmd;
  stat_t stat;

  hvn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hvn_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_height_sample  (in_height_sample),
    .cmd               (cmd),
    .stat              (stat),
    .out_normal_x      (out_normal_x),
    .out_normal_y      (out_normal_y),
    .out_normal_z      (out_normal_z),
    .out_vertex_column (out_vertex_column),
    .out_vertex_row    (out_vertex_row),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

### dv/hvn_normal_checker.sv
`timescale 1ns / 1ps

module hvn_normal_checker
  import hvn_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [HT_W-1:0]          in_height_sample,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [OUTS_W-1:0] out_normal_x,
  input  logic [OUTY_W-1:0]        out_normal_y,
  input  logic signed [OUTS_W-1:0] out_normal_z,
  input  logic [VTX_W-1:0]         out_vertex_column,
  input  logic [VTX_W-1:0]         out_vertex_row,
  input  logic                     out_last_of_run,
  output int                       errors,
  output int                       pending,
  output int                       normals_seen
);

  typedef struct packed {
    logic signed [OUTS_W-1:0] nx;
    logic [OUTY_W-1:0]        ny;
    logic signed [OUTS_W-1:0] nz;
    logic [VTX_W-1:0]         col;
    logic [VTX_W-1:0]         row;
    logic                     last;
  } normal_t;

  normal_t       normal_q[$];
  logic [7:0]    heights[3][MAX_WIDTH_DEF];
  logic [CFG_W-1:0] width_reg, height_reg;
  int            col_cnt, row_cnt;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int top);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > top) return top;
    return v;
  endfunction

  // largest q in [0,16384] with q*sqrt(len2) <= 16384*mag
  function automatic int unit_q14(int mag, longint len2);
    longint rhs;
    int lo, hi, mid;
    rhs = (longint'(mag) * mag) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (longint'(mid) * mid * len2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic [15:0] signed_q14(int s, longint len2);
    int q;
    q = unit_q14(s < 0 ? -s : s, len2);
    return s < 0 ? 16'(-q) : 16'(q);
  endfunction

  function automatic int ht(int c, int r);
    return heights[r % 3][c];
  endfunction

  function automatic normal_t vertex_normal(int c, int r, int w, int h, logic last);
    normal_t n;
    int sx, sy, sz, cc, cr, h00;
    logic [15:0] ty;
    longint len2;
    sx = 0; sy = 0; sz = 0;
    for (int k = 0; k < 4; k++) begin
      cc = c - 1 + (k & 1);
      cr = r - 1 + (k >> 1);
      if ((k & 1) == 0 && c == 0) continue;
      if ((k >> 1) == 0 && r == 0) continue;
      if (cc > w - 2 || cr > h - 2) continue;
      h00 = ht(cc, cr);
      sx += h00 - ht(cc + 1, cr);
      sy += FACE_UP;
      sz += h00 - ht(cc, cr + 1);
    end
    len2 = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
    if (len2 == 0) len2 = 1;
    n.nx = signed_q14(sx, len2);
    ty = signed_q14(sy, len2);
    n.ny = ty[14:0];
    n.nz = signed_q14(sz, len2);
    n.col = c[9:0];
    n.row = r[9:0];
    n.last = last;
    return n;
  endfunction

  task automatic take_sample(logic [7:0] hs);
    int w, h, c, r;
    logic final_row;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    c = col_cnt;
    r = row_cnt;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    heights[r % 3][c] = hs;
    if (r >= 1) begin
      final_row = (r == h - 1);
      normal_q.push_back(vertex_normal(c, r - 1, w, h, !final_row));
      if (final_row) normal_q.push_back(vertex_normal(c, r, w, h, 1'b1));
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    normals_seen = 0;
  end

  always @(posedge clk) begin
    normal_t e;
    if (!rst_n) begin
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      col_cnt = 0;
      row_cnt = 0;
      normal_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAP_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
        col_cnt = 0;
        row_cnt = 0;
      end
      if (in_valid && in_ready) take_sample(in_height_sample);
      if (out_valid && out_ready) begin
        normals_seen++;
        if (normal_q.size() == 0) begin
          report("unexpected normal beat, queued", 0, 1);
        end else begin
          e = normal_q.pop_front();
          if (out_normal_x !== e.nx) report("normal_x", out_normal_x, e.nx);
          if (out_normal_y !== e.ny) report("normal_y", out_normal_y, e.ny);
          if (out_normal_z !== e.nz) report("normal_z", out_normal_z, e.nz);
          if (out_vertex_column !== e.col) report("vertex_column", out_vertex_column, e.col);
          if (out_vertex_row !== e.row) report("vertex_row", out_vertex_row, e.row);
          if (out_last_of_run !== e.last) report("last_of_run", out_last_of_run, e.last);
        end
      end
    end
    pending = normal_q.size();
  end

endmodule

### dv/tb_heightmap_vertex_normal_stream.sv
`timescale 1ns / 1ps

module tb_heightmap_vertex_normal_stream;
  import hvn_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [0:0] cfg_index = REG_MAP_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [HT_W-1:0] in_height_sample = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [OUTS_W-1:0] out_normal_x, out_normal_z;
  logic [OUTY_W-1:0] out_normal_y;
  logic [VTX_W-1:0] out_vertex_column, out_vertex_row;
  logic out_last_of_run;

  int errors, pending, normals_seen;
  int samples_sent = 0;
  bit send_idle = 0, recv_stall = 0, long_hold_req = 0;
  int idle_pct = 88;
  int hold_left = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  heightmap_vertex_normal_stream dut (.*);

  hvn_normal_checker u_chk (.*);

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_left <= 2000;
      out_ready <= 0;
    end else begin
      out_ready <= recv_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
    end
  end

  task automatic send_sample(logic [7:0] hs);
    if (send_idle) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_height_sample <= hs;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // drain, then let any first-row beat settle before touching a register
  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_map(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
  endtask

  function automatic logic [7:0] rand_height();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    #12_000_000;
    $display("[heightmap_vertex_normal_stream] ERROR");
    $finish;
  end

  initial begin
    int w, h, n;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // below-minimum sizes clamp to a 2x2 map
    set_map(11'd0, 11'd1);
    send_sample(8'd0); send_sample(8'd255); send_sample(8'd255); send_sample(8'd0);
    send_sample(8'd255); send_sample(8'd0); send_sample(8'd0); send_sample(8'd255);
    // flat and steep 3x3
    set_map(11'd3, 11'd3);
    repeat (9) send_sample(8'd128);
    for (int i = 0; i < 9; i++) send_sample(i[0] ? 8'd255 : 8'd0);

    // widest row, clamped from the top of the register range; first samples only
    set_map(11'd2047, 11'd2);
    repeat (12) send_sample(rand_height());
    set_map(11'd1024, 11'd2);
    repeat (12) send_sample(rand_height());
    // tallest map, only its top rows
    set_map(11'd2, 11'd2047);
    repeat (16) send_sample(rand_height());
    set_map(11'd2, 11'd1024);
    repeat (10) send_sample(rand_height());

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1) || (phase == 3);
      recv_stall = (phase == 2) || (phase == 3);
      idle_pct = (phase == 3) ? 28 : 88;
      n = 0;
      while (n < 96) begin
        case ($urandom_range(7))
          0: w = $urandom_range(1, 0) ? 0 : 2047;
          default: w = $urandom_range(2, 6);
        endcase
        h = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 5);
        if (phase == 0 && n == 0) w = 4;
        set_map(CFG_W'(w), CFG_W'(h));
        if (phase == 0 && n == 0) begin
          long_hold_req = 1;
          repeat (24) send_sample(rand_height());
          n += 24;
        end
        w = (w < 2) ? 2 : (w > 1024) ? 1024 : w;
        h = (h < 2) ? 2 : h;
        // whole maps half the time, else cut short or running on for up to one more map
        case ($urandom_range(3))
          0: h = $urandom_range(1, h * w);
          1: h = w * h + $urandom_range(1, w * h);
          default: h = w * h;
        endcase
        if (w == 1024) h = $urandom_range(4, 12);
        repeat (h) send_sample(rand_height());
        n += h;
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d height samples and %0d vertex normals over clamped, minimal",
             samples_sent, normals_seen);
    $display("and widest/tallest maps, with sender gaps, receiver stalls and a long hold");
    if (errors == 0) begin
      $display("[heightmap_vertex_normal_stream] OK");
    end else begin
      $display("[heightmap_vertex_normal_stream] ERROR");
    end
    $finish;
  end

endmodule
